// ===== hw/rtl/aes256_pkg.sv =====
// aes256_pkg: shared constants, types and functions for the aes-256 encrypt core
// holds the s-box table, round constants, round helpers and key register codes
// no dependencies
`timescale 1ns / 1ps

package aes256_pkg;

  localparam int NUM_ROUNDS   = 14;
  localparam int NUM_RK_WORDS = 60;
  localparam int BLOCK_W      = 128;
  localparam int KEY_REG_W    = 64;
  localparam int CFG_IDX_W    = 2;

  typedef logic [7:0]   byte_t;
  typedef logic [31:0]  word_t;
  typedef logic [127:0] block_t;

  // key register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_0 = 2'd0,
    REG_KEY_1 = 2'd1,
    REG_KEY_2 = 2'd2,
    REG_KEY_3 = 2'd3
  } key_reg_t;

  localparam byte_t SBOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  localparam byte_t RCON [7] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40};

  function automatic word_t sbox_word(input word_t w);
    sbox_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic byte_t xtime(input byte_t b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
  endfunction

  // byte k of the block sits at bits 127-8k down
  function automatic byte_t get_byte(input block_t b, input int k);
    get_byte = b[BLOCK_W-1-8*k -: 8];
  endfunction

  // sub bytes and shift rows together
  function automatic block_t sub_shift(input block_t b);
    block_t t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[BLOCK_W-1-8*(4*c+r) -: 8] = SBOX[get_byte(b, 4*((c+r)%4)+r)];
      end
    end
    sub_shift = t;
  endfunction

  function automatic block_t mix_cols(input block_t b);
    block_t t;
    byte_t a0, a1, a2, a3;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(b, 4*c);
      a1 = get_byte(b, 4*c+1);
      a2 = get_byte(b, 4*c+2);
      a3 = get_byte(b, 4*c+3);
      t[BLOCK_W-1-8*(4*c)   -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      t[BLOCK_W-1-8*(4*c+1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      t[BLOCK_W-1-8*(4*c+2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      t[BLOCK_W-1-8*(4*c+3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    mix_cols = t;
  endfunction

endpackage

// ===== hw/rtl/aes256_block_encrypt_core.sv =====
// aes256_block_encrypt_core: pipelined aes-256 ecb encrypt, one word per ready cycle
// depends on aes256_pkg for the s-box, round functions and key register codes
`timescale 1ns / 1ps

// One 128-bit plaintext word enters per cycle while in_tready is high and passes
// one register stage for the initial key add and one for each of the 14 rounds,
// every round stage with its own s-box logic, so the sustained rate is one word per
// cycle while the output is not stalled. The key is written through cfg_* (index
// 0..3, byte 0 most significant); the user must do so only while the core is empty,
// which the core does not enforce. After a key write the schedule is rebuilt one
// round-key pair per cycle and in_tready stays low until it is done, also after
// reset. A stall on the output freezes the whole pipeline without losing any word.
module aes256_block_encrypt_core
  import aes256_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [KEY_REG_W-1:0]  cfg_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [BLOCK_W-1:0]    in_tdata,   // plain_high [63:0], plain_low [127:64]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [BLOCK_W-1:0]    out_tdata   // cipher_high [63:0], cipher_low [127:64]
);

  localparam int NSTG = NUM_ROUNDS + 1;

  // key registers
  logic [KEY_REG_W-1:0] key_r [4];
  // round keys as 128-bit round words
  block_t rk_r [NSTG];
  // schedule sweep: step 1..7 computes words 8s..8s+7, step 7 stores only 8s..8s+3
  logic [2:0] ks_step_r;
  logic       ks_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
    end else if (cfg_we) begin
      case (key_reg_t'(cfg_index))
        REG_KEY_0: key_r[0] <= cfg_data;
        REG_KEY_1: key_r[1] <= cfg_data;
        REG_KEY_2: key_r[2] <= cfg_data;
        REG_KEY_3: key_r[3] <= cfg_data;
        default:   ;
      endcase
    end
  end

  // next eight schedule words from the previous eight
  block_t ks_src_lo;
  block_t ks_src_hi;
  word_t  prev8 [8];
  word_t  next8 [8];
  word_t  tmp_w;
  always_comb begin
    // first step reads the key registers directly
    if (ks_step_r == 3'd1) begin
      ks_src_lo = {key_r[0], key_r[1]};
      ks_src_hi = {key_r[2], key_r[3]};
    end else begin
      ks_src_lo = rk_r[{ks_step_r - 3'd1, 1'b0}];
      ks_src_hi = rk_r[{ks_step_r - 3'd1, 1'b1}];
    end
    prev8[0] = ks_src_lo[127:96];
    prev8[1] = ks_src_lo[95:64];
    prev8[2] = ks_src_lo[63:32];
    prev8[3] = ks_src_lo[31:0];
    prev8[4] = ks_src_hi[127:96];
    prev8[5] = ks_src_hi[95:64];
    prev8[6] = ks_src_hi[63:32];
    prev8[7] = ks_src_hi[31:0];
    tmp_w = prev8[7];
    tmp_w = sbox_word({tmp_w[23:0], tmp_w[31:24]}) ^ {RCON[ks_step_r-3'd1], 24'h0};
    next8[0] = prev8[0] ^ tmp_w;
    next8[1] = prev8[1] ^ next8[0];
    next8[2] = prev8[2] ^ next8[1];
    next8[3] = prev8[3] ^ next8[2];
    next8[4] = prev8[4] ^ sbox_word(next8[3]);
    next8[5] = prev8[5] ^ next8[4];
    next8[6] = prev8[6] ^ next8[5];
    next8[7] = prev8[7] ^ next8[6];
  end

  // key schedule sweep; restarts on any key write
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      ks_busy_r <= 1'b1;
      ks_step_r <= 3'd1;
    end else if (ks_busy_r) begin
      if (ks_step_r == 3'd7) ks_busy_r <= 1'b0;
      else                   ks_step_r <= ks_step_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ks_busy_r) begin
      rk_r[0] <= {key_r[0], key_r[1]};
      rk_r[1] <= {key_r[2], key_r[3]};
      rk_r[{ks_step_r, 1'b0}] <= {next8[0], next8[1], next8[2], next8[3]};
      if (ks_step_r != 3'd7)
        rk_r[{ks_step_r, 1'b1}] <= {next8[4], next8[5], next8[6], next8[7]};
    end
  end

  // round pipeline
  logic   vld_r [NSTG];
  block_t st_r  [NSTG];
  logic   adv;

  assign adv        = !out_tvalid || out_tready;
  assign in_tready  = adv && !ks_busy_r;
  assign out_tvalid = vld_r[NSTG-1];
  assign out_tdata  = {st_r[NSTG-1][63:0], st_r[NSTG-1][127:64]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NSTG; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_tvalid && !ks_busy_r;
      for (int i = 1; i < NSTG; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0] <= {in_tdata[63:0], in_tdata[127:64]} ^ rk_r[0];
      for (int i = 1; i < NSTG-1; i++)
        st_r[i] <= mix_cols(sub_shift(st_r[i-1])) ^ rk_r[i];
      st_r[NSTG-1] <= sub_shift(st_r[NSTG-2]) ^ rk_r[NSTG-1];
    end
  end

endmodule
